/* rtl/core/met_pkg.sv */
// Shared types, constants and functions of the escape-time pixel evaluator.
`default_nettype none

package met_pkg;

    localparam int PX_W      = 12;
    localparam int PY_W      = 11;
    localparam int CNT_W     = 13;
    localparam int ITER_W    = 12;
    localparam int RED_W     = 8;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = 31;
    localparam int FRAC_BITS = 28;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_X_STEP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_STEP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IN_SET_RED = 3'd5;

    localparam logic [STEP_W-1:0]  RST_X_STEP     = 31'd180044;
    localparam logic [STEP_W-1:0]  RST_Y_STEP     = 31'd205810;
    localparam logic [CFG_W-1:0]   RST_CENTER_RE  = -32'sd221459251;
    localparam logic [CFG_W-1:0]   RST_CENTER_IM  = 32'sd44721347;
    localparam logic [ITER_W-1:0]  RST_MAX_ITER   = 12'd36;
    localparam logic [RED_W-1:0]   RST_IN_SET_RED = 8'd155;

    // shade = min(255, floor(13*count/5)); saturates from this count on
    localparam logic [CNT_W-1:0] SAT_COUNT   = 13'd99;
    localparam logic [10:0]      SHADE_MUL   = 11'd13;
    localparam logic [26:0]      RECIP5      = 27'd52429;
    localparam int               RECIP_SHIFT = 18;

    typedef struct packed {
        logic [PX_W-1:0] pixel_x;
        logic [PY_W-1:0] pixel_y;
    } t_pixel;

    typedef struct packed {
        logic [RED_W-1:0] red;
        logic [CNT_W-1:0] iter_count;
        logic             in_set;
    } t_result;

    typedef struct packed {
        logic load;    // register c products from the incoming pixel
        logic init;    // form c, clear z and count
        logic square;  // register squares and cross product of z
        logic step;    // advance z and count
        logic finish;  // register the result
    } t_cmd;

    typedef struct packed {
        logic cont;    // z inside radius and count within limit
    } t_stat;

    function automatic logic [RED_W-1:0] f_shade(input logic [CNT_W-1:0] count);
        logic [10:0] v;
        logic [26:0] q;
        v = 11'(count[6:0]) * SHADE_MUL;
        q = 27'(v) * RECIP5;
        if (count >= SAT_COUNT) begin
            return {RED_W{1'b1}};
        end
        return q[RECIP_SHIFT+RED_W-1:RECIP_SHIFT];
    endfunction

endpackage

`default_nettype wire

/* rtl/core/mandelbrot_escape_time_pixel.sv */
// Top level of the escape-time pixel evaluator: sequencer plus datapath.
// One pixel at a time: busy is high from the start transfer until the o_done strobe and
//   falls in the strobe cycle, so the next start can be taken while the result is
//   shown. Each iteration runs the square/cross-product multipliers, then the
//   add-and-clamp stage.
// Results cannot be stalled. Synchronous active-low reset clears control state and
//   loads the default view registers.
`default_nettype none

module mandelbrot_escape_time_pixel #(
    parameter int SCREEN_WIDTH  = 2560,
    parameter int SCREEN_HEIGHT = 1600,
    parameter int COORD_WIDTH   = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // pixel command: transfer when start is high and busy is low
    input  wire                                 start,
    output logic                                busy,
    input  met_pkg::t_pixel                     i_pixel,
    // result strobe, valid for exactly one cycle
    output logic                                o_done,
    output met_pkg::t_result                    o_result,
    // configuration write port, no read-back
    input  wire                                 i_cfg_we,
    input  wire  [met_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [met_pkg::CFG_W-1:0]           i_cfg_wdata
);

    met_pkg::t_cmd  cmd;
    met_pkg::t_stat stat;

    // Sequencer: idle -> form c -> (square, accumulate)+ -> strobe.
    met_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    // Datapath: hold the view registers, map the pixel to c, iterate z and
    // register the count, in-set flag and red shade on finish.
    met_dpath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COORD_WIDTH   (COORD_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_pixel     (i_pixel),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_stat      (stat),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

/* rtl/core/met_ctrl.sv */
// Sequencer of the escape-time evaluator: issues load, iteration and finish commands.
`default_nettype none

module met_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_start,
    input  met_pkg::t_stat i_stat,
    output met_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CADD = 2'd1;
    localparam logic [1:0] ST_ZMUL = 2'd2;
    localparam logic [1:0] ST_ZACC = 2'd3;

    logic [1:0] r_state, n_state;
    logic       r_done, n_done;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CADD;
                end
            end
            ST_CADD: begin
                o_cmd.init = 1'b1;
                n_state    = ST_ZMUL;
            end
            ST_ZMUL: begin
                o_cmd.square = 1'b1;
                n_state      = ST_ZACC;
            end
            ST_ZACC: begin
                if (i_stat.cont) begin
                    o_cmd.step = 1'b1;
                    n_state    = ST_ZMUL;
                end else begin
                    o_cmd.finish = 1'b1;
                    n_done       = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = r_done;

endmodule

`default_nettype wire

/* rtl/core/met_dpath.sv */
// Datapath: configuration store, point mapping, z iteration and result register.
`default_nettype none

module met_dpath #(
    parameter int SCREEN_WIDTH  = 2560,
    parameter int SCREEN_HEIGHT = 1600,
    parameter int COORD_WIDTH   = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  met_pkg::t_cmd                       i_cmd,
    input  met_pkg::t_pixel                     i_pixel,
    input  wire                                 i_cfg_we,
    input  wire  [met_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire  [met_pkg::CFG_W-1:0]           i_cfg_wdata,
    output met_pkg::t_stat                      o_stat,
    output met_pkg::t_result                    o_result
);

    localparam int HX  = SCREEN_WIDTH / 2;
    localparam int HY  = SCREEN_HEIGHT / 2;
    localparam int XLW = ($clog2(HX + 1) > met_pkg::PX_W) ? $clog2(HX + 1) : met_pkg::PX_W;
    localparam int YLW = ($clog2(HY + 1) > met_pkg::PY_W) ? $clog2(HY + 1) : met_pkg::PY_W;
    localparam int XW  = XLW + 1;
    localparam int YW  = YLW + 1;
    localparam int PXW = XW + met_pkg::CFG_W;
    localparam int PYW = YW + met_pkg::CFG_W;
    // squares are only used for parts below 2.0, which fit 30 signed bits
    localparam int MW  = (COORD_WIDTH < 30) ? COORD_WIDTH : 30;
    localparam int A0  = (2 * MW + 2 > COORD_WIDTH) ? 2 * MW + 2 : COORD_WIDTH;
    localparam int A1  = (PXW > PYW) ? PXW : PYW;
    localparam int A2  = (A0 > A1) ? A0 : A1;
    localparam int AW  = ((A2 > 2 * met_pkg::FRAC_BITS + 4) ? A2 : 2 * met_pkg::FRAC_BITS + 4) + 2;

    localparam logic signed [AW-1:0] CMAX =
        {{(AW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [AW-1:0] CMIN =
        {{(AW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};
    localparam logic signed [AW-1:0] TWO  = AW'(1) << (met_pkg::FRAC_BITS + 1);
    localparam logic signed [AW-1:0] NTWO = -TWO;
    localparam logic signed [AW-1:0] FOUR = AW'(1) << (2 * met_pkg::FRAC_BITS + 2);

    function automatic logic signed [COORD_WIDTH-1:0] f_clamp(input logic signed [AW-1:0] v);
        if (v > CMAX) begin
            return CMAX[COORD_WIDTH-1:0];
        end else if (v < CMIN) begin
            return CMIN[COORD_WIDTH-1:0];
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    // configuration registers
    logic [met_pkg::STEP_W-1:0] r_x_step, r_y_step;
    logic [met_pkg::CFG_W-1:0]  r_center_re, r_center_im;
    logic [met_pkg::ITER_W-1:0] r_max_iter;
    logic [met_pkg::RED_W-1:0]  r_in_set_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_step     <= met_pkg::RST_X_STEP;
            r_y_step     <= met_pkg::RST_Y_STEP;
            r_center_re  <= met_pkg::RST_CENTER_RE;
            r_center_im  <= met_pkg::RST_CENTER_IM;
            r_max_iter   <= met_pkg::RST_MAX_ITER;
            r_in_set_red <= met_pkg::RST_IN_SET_RED;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                met_pkg::CFG_X_STEP:     r_x_step     <= i_cfg_wdata[met_pkg::STEP_W-1:0];
                met_pkg::CFG_Y_STEP:     r_y_step     <= i_cfg_wdata[met_pkg::STEP_W-1:0];
                met_pkg::CFG_CENTER_RE:  r_center_re  <= i_cfg_wdata;
                met_pkg::CFG_CENTER_IM:  r_center_im  <= i_cfg_wdata;
                met_pkg::CFG_MAX_ITER:   r_max_iter   <= i_cfg_wdata[met_pkg::ITER_W-1:0];
                met_pkg::CFG_IN_SET_RED: r_in_set_red <= i_cfg_wdata[met_pkg::RED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pixel offsets from screen centre and their products with the steps
    logic signed [XW-1:0]  px_off;
    logic signed [YW-1:0]  py_off;
    logic signed [met_pkg::CFG_W-1:0] x_step_s, y_step_s;
    logic signed [PXW-1:0] r_cprod_re;
    logic signed [PYW-1:0] r_cprod_im;

    assign px_off   = $signed({{(XW-met_pkg::PX_W){1'b0}}, i_pixel.pixel_x}) - $signed(XW'(HX));
    assign py_off   = $signed(YW'(HY)) - $signed({{(YW-met_pkg::PY_W){1'b0}}, i_pixel.pixel_y});
    assign x_step_s = $signed({1'b0, r_x_step});
    assign y_step_s = $signed({1'b0, r_y_step});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cprod_re <= PXW'(px_off) * PXW'(x_step_s);
            r_cprod_im <= PYW'(py_off) * PYW'(y_step_s);
        end
    end

    logic signed [AW-1:0] csum_re, csum_im;
    assign csum_re = {{(AW-PXW){r_cprod_re[PXW-1]}}, r_cprod_re}
                   + {{(AW-met_pkg::CFG_W){r_center_re[met_pkg::CFG_W-1]}}, r_center_re};
    assign csum_im = {{(AW-PYW){r_cprod_im[PYW-1]}}, r_cprod_im}
                   + {{(AW-met_pkg::CFG_W){r_center_im[met_pkg::CFG_W-1]}}, r_center_im};

    // iteration registers
    logic signed [COORD_WIDTH-1:0] r_cr, r_ci, r_zr, r_zi;
    logic [met_pkg::CNT_W-1:0]     r_count;
    logic signed [2*MW-1:0]        r_sq_r, r_sq_i, r_xp;
    logic signed [MW-1:0]          op_r, op_i;

    assign op_r = r_zr[MW-1:0];
    assign op_i = r_zi[MW-1:0];

    logic signed [AW-1:0] zr_e, zi_e, cr_e, ci_e, sqr_e, sqi_e, xp_e;
    logic signed [AW-1:0] sumsq, re_v, im_v;
    logic                 in_radius, count_ok;

    assign zr_e  = {{(AW-COORD_WIDTH){r_zr[COORD_WIDTH-1]}}, r_zr};
    assign zi_e  = {{(AW-COORD_WIDTH){r_zi[COORD_WIDTH-1]}}, r_zi};
    assign cr_e  = {{(AW-COORD_WIDTH){r_cr[COORD_WIDTH-1]}}, r_cr};
    assign ci_e  = {{(AW-COORD_WIDTH){r_ci[COORD_WIDTH-1]}}, r_ci};
    assign sqr_e = {{(AW-2*MW){r_sq_r[2*MW-1]}}, r_sq_r};
    assign sqi_e = {{(AW-2*MW){r_sq_i[2*MW-1]}}, r_sq_i};
    assign xp_e  = {{(AW-2*MW){r_xp[2*MW-1]}}, r_xp};

    assign sumsq = sqr_e + sqi_e;
    // floor rescale; the cross product is doubled by shifting one bit less
    assign re_v  = ((sqr_e - sqi_e) >>> met_pkg::FRAC_BITS) + cr_e;
    assign im_v  = (xp_e >>> (met_pkg::FRAC_BITS - 1)) + ci_e;

    assign in_radius = !(zr_e >= TWO || zr_e <= NTWO || zi_e >= TWO || zi_e <= NTWO)
                       && (sumsq < FOUR);
    assign count_ok  = (r_count <= {1'b0, r_max_iter});
    assign o_stat.cont = in_radius && count_ok;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_cr    <= f_clamp(csum_re);
            r_ci    <= f_clamp(csum_im);
            r_zr    <= '0;
            r_zi    <= '0;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_zr    <= f_clamp(re_v);
            r_zi    <= f_clamp(im_v);
            r_count <= r_count + 1'b1;
        end
        if (i_cmd.square) begin
            r_sq_r <= op_r * op_r;
            r_sq_i <= op_i * op_i;
            r_xp   <= op_r * op_i;
        end
    end

    // result register
    logic in_set_v;
    assign in_set_v = (r_count >= {1'b0, r_max_iter});

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_result.iter_count <= r_count;
            o_result.in_set     <= in_set_v;
            o_result.red        <= in_set_v ? r_in_set_red : met_pkg::f_shade(r_count);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/met_checker.sv */
// Port-level checks of the escape-time evaluator and their bind to the top level.
`default_nettype none

module met_checker (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_start,
    input wire              i_busy,
    input wire              i_done,
    input met_pkg::t_result i_result
);

    // an accepted pixel always keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !i_busy |=> i_busy)
        else $error("accepted pixel did not raise busy");

    // the strobe comes only once the block has gone idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> !i_busy)
        else $error("result strobe while busy");

    // a strobe lasts one cycle
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |=> !i_done)
        else $error("result strobe longer than one cycle");

    // at least one iteration is always performed
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> i_result.iter_count != '0)
        else $error("result with zero iterations");

endmodule

bind mandelbrot_escape_time_pixel met_checker u_met_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_done   (o_done),
    .i_result (o_result)
);

`default_nettype wire

/* tb/sv/mandelbrot_escape_time_pixel_checker.sv */
`timescale 1ns / 1ps
// Checker for the escape-time pixel evaluator: predicts each result and compares it.
module mandelbrot_escape_time_pixel_checker #(
    parameter int SCREEN_WIDTH  = 2560,
    parameter int SCREEN_HEIGHT = 1600,
    parameter int COORD_WIDTH   = 32
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  wire                           i_busy,
    input  met_pkg::t_pixel               i_pixel,
    input  wire                           i_done,
    input  met_pkg::t_result              i_result,
    input  wire                           i_cfg_we,
    input  wire  [met_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [met_pkg::CFG_W-1:0]     i_cfg_wdata,
    output int                            o_fail_count,
    output int                            o_pending
);
    import met_pkg::*;

    // shadow copy of the view registers
    logic [STEP_W-1:0]        step_re;
    logic [STEP_W-1:0]        step_im;
    logic signed [CFG_W-1:0]  view_re;
    logic signed [CFG_W-1:0]  view_im;
    logic [ITER_W-1:0]        iter_limit;
    logic [RED_W-1:0]         inside_red;

    t_result escape_q[$];
    int      mismatches = 0;
    int      results_seen = 0;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch on %s at result %0d: got %0d, expected %0d",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    function automatic longint sat_coord(input longint v);
        longint hi;
        hi = (longint'(1) << (COORD_WIDTH - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    // a part of magnitude 2.0 or more escapes without squaring
    function automatic bit orbit_bounded(input longint zr, input longint zi);
        longint two;
        two = longint'(1) << (FRAC_BITS + 1);
        if (zr >= two || zr <= -two || zi >= two || zi <= -two) return 1'b0;
        return (zr * zr + zi * zi) < (longint'(1) << (2 * FRAC_BITS + 2));
    endfunction

    function automatic t_result predict_escape(input t_pixel p);
        longint  cr;
        longint  ci;
        longint  zr;
        longint  zi;
        longint  re_next;
        longint  im_next;
        int      count;
        int      shade;
        t_result r;
        cr = sat_coord(longint'(view_re)
                       + (longint'(p.pixel_x) - SCREEN_WIDTH / 2) * longint'(step_re));
        ci = sat_coord(longint'(view_im)
                       + (SCREEN_HEIGHT / 2 - longint'(p.pixel_y)) * longint'(step_im));
        zr = 0;
        zi = 0;
        count = 0;
        while (orbit_bounded(zr, zi) && count <= int'(iter_limit)) begin
            re_next = (zr * zr - zi * zi) >>> FRAC_BITS;
            im_next = (zr * zi) >>> (FRAC_BITS - 1);
            zr = sat_coord(re_next + cr);
            zi = sat_coord(im_next + ci);
            count++;
        end
        shade = (130 * count) / 50;
        if (shade > 255) shade = 255;
        r.red        = (count < int'(iter_limit)) ? RED_W'(shade) : inside_red;
        r.iter_count = CNT_W'(count);
        r.in_set     = (count >= int'(iter_limit));
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            step_re    = RST_X_STEP;
            step_im    = RST_Y_STEP;
            view_re    = RST_CENTER_RE;
            view_im    = RST_CENTER_IM;
            iter_limit = RST_MAX_ITER;
            inside_red = RST_IN_SET_RED;
            escape_q.delete();
        end else begin
            // check the result first: it belongs to an earlier transfer
            if (i_done) begin
                if (escape_q.size() == 0) begin
                    report_mismatch("unexpected result", i_result.iter_count, '0);
                end else begin
                    want = escape_q.pop_front();
                    if (i_result.red !== want.red)
                        report_mismatch("red", i_result.red, want.red);
                    if (i_result.iter_count !== want.iter_count)
                        report_mismatch("iter_count", i_result.iter_count, want.iter_count);
                    if (i_result.in_set !== want.in_set)
                        report_mismatch("in_set", i_result.in_set, want.in_set);
                end
                results_seen++;
            end
            if (i_start && !i_busy) escape_q.push_back(predict_escape(i_pixel));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_X_STEP:     step_re    = i_cfg_wdata[STEP_W-1:0];
                    CFG_Y_STEP:     step_im    = i_cfg_wdata[STEP_W-1:0];
                    CFG_CENTER_RE:  view_re    = i_cfg_wdata;
                    CFG_CENTER_IM:  view_im    = i_cfg_wdata;
                    CFG_MAX_ITER:   iter_limit = i_cfg_wdata[ITER_W-1:0];
                    CFG_IN_SET_RED: inside_red = i_cfg_wdata[RED_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending    <= escape_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/mandelbrot_escape_time_pixel_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the escape-time pixel evaluator: stimulus, register traffic and verdict.
module mandelbrot_escape_time_pixel_tb;
    import met_pkg::*;

    localparam int SCREEN_WIDTH  = 2560;
    localparam int SCREEN_HEIGHT = 1600;
    localparam int COORD_WIDTH   = 32;

    localparam int     RANDOM_PIXELS = 1950;
    localparam int     CALM_TAIL     = 200;           // last transfers go with no idling
    localparam int     SETTLE_CYCLES = 2 * 4096 + 8;  // longest latency, plus margin
    localparam longint RUN_LIMIT_NS  = 100_000_000;

    // indexes beyond the register list; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Q4.28 views of the complex plane
    localparam logic [CFG_W-1:0] QTWO      = 32'h2000_0000;
    localparam logic [CFG_W-1:0] QNEG_TWO  = 32'hE000_0000;
    localparam logic [CFG_W-1:0] QCUSP     = 32'd67162551;  // just right of the cusp at 0.25
    localparam int unsigned      RE_SPAN   = 32'h4000_0000; // 4.0 wide, from -2.5
    localparam int unsigned      RE_LOW    = 32'd671088640;
    localparam int unsigned      IM_SPAN   = 32'd805306368; // 3.0 high, from -1.5
    localparam int unsigned      IM_LOW    = 32'd402653184;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 start       = 1'b0;
    logic                 busy;
    t_pixel               i_pixel     = '0;
    logic                 o_done;
    t_result              o_result;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_wdata = '0;

    int fail_count;
    int pending;
    bit idle_on = 1'b1;

    mandelbrot_escape_time_pixel #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .COORD_WIDTH  (COORD_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pixel    (i_pixel),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    // The checker sees every channel: it predicts on each pixel transfer, tracks
    // register writes and reports back how many mismatches and open results it holds.
    mandelbrot_escape_time_pixel_checker #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT),
        .COORD_WIDTH  (COORD_WIDTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_busy      (busy),
        .i_pixel     (i_pixel),
        .i_done      (o_done),
        .i_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Backstop: a hung handshake or a missing result ends the run here.
    initial begin
        #(RUN_LIMIT_NS);
        $display("mandelbrot_escape_time_pixel regression: fail");
        $finish;
    end

    // Offer one pixel and hold it until the block takes it. Start stays high after the
    // transfer so that back-to-back pixels need no second assignment in the same step;
    // an idle burst, when it comes, lowers it until the next pixel.
    task automatic send_pixel(input logic [PX_W-1:0] x, input logic [PY_W-1:0] y);
        t_pixel p;
        p.pixel_x = x;
        p.pixel_y = y;
        start   <= 1'b1;
        i_pixel <= p;
        do begin
            @(posedge i_clk);
        end while (busy);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // Drop start and hold until every predicted result has been seen. The checker's
    // count is registered, so the loop waits on the clock before it first reads it.
    task automatic wait_results();
        start <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load a whole view once the block has gone idle.
    task automatic set_view(input logic [CFG_W-1:0] xs, input logic [CFG_W-1:0] ys,
                            input logic [CFG_W-1:0] cre, input logic [CFG_W-1:0] cim,
                            input logic [CFG_W-1:0] limit, input logic [CFG_W-1:0] red);
        wait_results();
        write_reg(CFG_X_STEP, xs);
        write_reg(CFG_Y_STEP, ys);
        write_reg(CFG_CENTER_RE, cre);
        write_reg(CFG_CENTER_IM, cim);
        write_reg(CFG_MAX_ITER, limit);
        write_reg(CFG_IN_SET_RED, red);
    endtask

    // Steps stay mostly small so a screen spans a few units of the plane; now and then
    // take zero, the top value or anything. The bit above the register is random.
    function automatic logic [CFG_W-1:0] pick_step();
        logic [CFG_W-1:0] v;
        v = CFG_W'($urandom_range(0, 1 << 19));
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = '0;
            2: v = 32'h7FFF_FFFF;
            default: ;
        endcase
        v[CFG_W-1] = 1'($urandom);
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_centre(input int unsigned span,
                                                     input int unsigned low);
        if ($urandom_range(0, 5) == 0) return $urandom;
        return $urandom_range(0, span) - low;
    endfunction

    // Between phases: rewrite a random subset of the view, always the limit. A heavy
    // phase uses a high limit for a handful of pixels only, to keep the run short.
    task automatic reprogram_random(output int span);
        bit          heavy;
        int unsigned limit;
        heavy = ($urandom_range(0, 9) == 0);
        if (heavy) limit = $urandom_range(121, 600);
        else if ($urandom_range(0, 15) == 0) limit = $urandom_range(0, 2);
        else limit = $urandom_range(3, 120);
        wait_results();
        if ($urandom_range(0, 1)) write_reg(CFG_X_STEP, pick_step());
        if ($urandom_range(0, 1)) write_reg(CFG_Y_STEP, pick_step());
        if ($urandom_range(0, 1)) write_reg(CFG_CENTER_RE, pick_centre(RE_SPAN, RE_LOW));
        if ($urandom_range(0, 1)) write_reg(CFG_CENTER_IM, pick_centre(IM_SPAN, IM_LOW));
        write_reg(CFG_MAX_ITER, {20'($urandom), 12'(limit)});
        if ($urandom_range(0, 1)) write_reg(CFG_IN_SET_RED, $urandom);
        if ($urandom_range(0, 15) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO, $urandom);
        span    = heavy ? $urandom_range(8, 20) : $urandom_range(40, 120);
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        int sent;
        int span;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Default view straight out of reset: screen corners, centre and pixels
        // beyond the screen on either axis.
        send_pixel(0, 0);
        send_pixel(2559, 1599);
        send_pixel(1280, 800);
        send_pixel(4095, 2047);
        send_pixel(0, 2047);
        send_pixel(4095, 0);

        // Limit of zero: one iteration still happens and the point counts as inside.
        // Junk above the twelve limit bits must be dropped.
        set_view(32'd180044, 32'd205810, -32'sd221459251, 32'sd44721347,
                 32'hFFFF_F000, 32'd0);
        send_pixel(1280, 800);
        send_pixel(0, 0);

        // Largest steps and offsets: c clamps at the coordinate range and escapes at once.
        set_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'd36, 32'd255);
        send_pixel(0, 0);
        send_pixel(4095, 2047);
        send_pixel(1280, 800);
        send_pixel(4095, 0);

        // Parts sitting exactly on magnitude two escape without squaring.
        set_view(32'd0, 32'd0, QTWO, 32'd0, 32'd36, 32'd155);
        send_pixel(17, 3);
        set_view(32'd0, 32'd0, QNEG_TWO, 32'd0, 32'd36, 32'd155);
        send_pixel(0, 0);
        set_view(32'd0, 32'd0, 32'd0, QTWO, 32'd36, 32'd155);
        send_pixel(5, 5);

        // Near the cusp orbits escape slowly: long counts push the shade into
        // saturation, and the closest pixel stays inside. Spare indexes go in too.
        set_view(32'd4096, 32'd0, QCUSP, 32'd0, 32'd300, 32'd77);
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
        send_pixel(1280, 0);
        send_pixel(1290, 0);
        send_pixel(1270, 0);
        send_pixel(1400, 0);

        // Top limit at the origin: the count runs to its widest value.
        set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd4095, 32'd200);
        send_pixel(0, 0);

        // Limit of one at the origin.
        set_view(32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd200);
        send_pixel(1280, 800);

        // Random phases: each starts from an idle block with a fresh view, then
        // streams pixels, mostly on the screen and now and then anywhere.
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            reprogram_random(span);
            for (int k = 0; k < span && sent < RANDOM_PIXELS; k++) begin
                if (sent >= RANDOM_PIXELS - CALM_TAIL) idle_on = 1'b0;
                // hold off now and then until the block has emptied
                if (idle_on && $urandom_range(0, 199) == 0) wait_results();
                if ($urandom_range(0, 6) == 0)
                    send_pixel(PX_W'($urandom), PY_W'($urandom));
                else
                    send_pixel(PX_W'($urandom_range(0, SCREEN_WIDTH - 1)),
                               PY_W'($urandom_range(0, SCREEN_HEIGHT - 1)));
                sent++;
            end
        end

        // Let the last result arrive, then watch a while longer for stray strobes.
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("mandelbrot_escape_time_pixel regression: pass");
        end else begin
            $display("mandelbrot_escape_time_pixel regression: fail");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/met_pkg.sv
rtl/core/met_ctrl.sv
rtl/core/met_dpath.sv
rtl/core/mandelbrot_escape_time_pixel.sv
rtl/core/met_checker.sv
tb/sv/mandelbrot_escape_time_pixel_checker.sv
tb/sv/mandelbrot_escape_time_pixel_tb.sv
